FILE: hw/rtl/rszc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rszc_pkg
// Shared constants for the ring spike and zigzag cleaner.
// ----------------------------------------------------------------------------
package rszc_pkg;

	localparam int COORD_BITS_DEF      = 24;
	localparam int MAX_RING_POINTS_DEF = 65536;
	localparam int TOL_BITS            = 24;
	// tan(pi/360) is taken as TAN_NUM / 2^TAN_SHIFT
	localparam int TAN_NUM             = 572;
	localparam int TAN_SHIFT           = 16;
	localparam int QUEUE_DEPTH         = 2;

	// seen counter width for a given ring length limit
	function automatic int seen_bits(input int max_pts);
		return $clog2(max_pts + 1);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rszc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rszc_front
// Takes in vertices, keeps the sliding window and the ring head, counts the
// ring and hands a snapshot of each step to the job queue.
// ----------------------------------------------------------------------------
module rszc_front #(
	parameter int COORD_BITS      = 24,
	parameter int MAX_RING_POINTS = 65536
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic signed [COORD_BITS-1:0]           x_coord,
	input  wire logic signed [COORD_BITS-1:0]           y_coord,
	input  wire logic                                   ring_end,
	output logic [14*COORD_BITS+rszc_pkg::seen_bits(MAX_RING_POINTS):0] job_data,
	output logic                                        job_push,
	input  wire logic                                   job_full
);
	import rszc_pkg::*;

	localparam int SW = seen_bits(MAX_RING_POINTS);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pt_t;

	typedef struct packed {
		pt_t [3:0]       win;
		pt_t [2:0]       head;
		logic [SW-1:0]   seen;
		logic            last;
	} job_t;

	pt_t [3:0]     win_q;
	pt_t [2:0]     head_q;
	logic [SW-1:0] seen_q;

	pt_t           v;
	pt_t [2:0]     head_nx;
	logic [SW-1:0] seen_nx;
	logic          last;
	logic          accept;
	job_t          job;

	assign full    = job_full;
	assign accept  = push && !job_full;
	assign v.x     = x_coord;
	assign v.y     = y_coord;
	assign seen_nx = seen_q + SW'(1);
	// an overlong ring is closed at the limit
	assign last    = ring_end || (seen_nx >= SW'(MAX_RING_POINTS));

	always_comb begin
		head_nx = head_q;
		if (seen_q < SW'(3)) begin
			head_nx[seen_q[1:0]] = v;
		end
	end

	assign job.win  = {win_q[2:0], v};
	assign job.head = head_nx;
	assign job.seen = seen_nx;
	assign job.last = last;

	assign job_data = job;
	assign job_push = accept;

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q  <= {win_q[2:0], v};
			head_q <= head_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= last ? '0 : seen_nx;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rszc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rszc_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module rszc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  is_full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  is_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rszc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rszc_back
// Walks the kept positions of each job: fetches the four window vertices,
// runs the angle and distance tests over three stages and emits the vertex.
// ----------------------------------------------------------------------------
module rszc_back #(
	parameter int COORD_BITS      = 24,
	parameter int MAX_RING_POINTS = 65536
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [14*COORD_BITS+rszc_pkg::seen_bits(MAX_RING_POINTS):0] job_data,
	input  wire logic                                   job_valid,
	output logic                                        job_pop,
	input  wire logic [rszc_pkg::TOL_BITS-1:0]          tolerance,
	output logic                                        empty,
	input  wire logic                                   pop,
	output logic signed [COORD_BITS-1:0]                out_x,
	output logic signed [COORD_BITS-1:0]                out_y,
	output logic                                        out_end
);
	import rszc_pkg::*;

	localparam int SW = seen_bits(MAX_RING_POINTS);
	localparam int NW = SW + 1;
	localparam int D  = COORD_BITS + 1;
	localparam int P  = 2 * D;
	localparam int S  = P + 1;
	localparam int CW = S + TAN_SHIFT;
	localparam int QW = (S > 2 * TOL_BITS) ? S : 2 * TOL_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pt_t;

	typedef struct packed {
		pt_t [3:0]       win;
		pt_t [2:0]       head;
		logic [SW-1:0]   seen;
		logic            last;
	} job_t;

	typedef struct packed {
		logic signed [D-1:0] x;
		logic signed [D-1:0] y;
	} vec_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_DIFF  = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_DEC   = 5'b10000
	} state_t;

	state_t        state_q;
	logic [NW-1:0] np_q;
	logic [1:0]    n_q;

	job_t          job;
	pt_t [3:0]     p_s1;

	// angle vectors u, v at p1 and p2; distance vectors p0-p3, p0-p2, p0-p1
	vec_t          u1_s2, v1_s2, u2_s2, v2_s2, e3_s2, e2_s2, e1_s2;

	logic signed [P-1:0] a1_xx_s3, a1_yy_s3, a1_xy_s3, a1_yx_s3;
	logic signed [P-1:0] a2_xx_s3, a2_yy_s3, a2_xy_s3, a2_yx_s3;
	logic signed [P-1:0] e3_xx_s3, e3_yy_s3, e2_xx_s3, e2_yy_s3, e1_xx_s3, e1_yy_s3;
	logic [2*TOL_BITS-1:0] tol2_s3;

	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
	logic                         out_end_q;
	logic                         out_valid_q;

	assign job = job_data;

	// ---- fetch with wrap ----
	pt_t [3:0] fetch_pt;

	always_comb begin
		logic [NW-1:0] m;
		logic [NW-1:0] dd;
		logic [NW-1:0] sz;
		sz = NW'(job.seen);
		for (int i = 0; i < 4; i++) begin
			m = np_q + NW'(i);
			if (job.last) begin
				// np stays below the ring size, so up to three subtractions finish the wrap
				for (int k = 0; k < 3; k++) begin
					if (m >= sz) begin
						m = m - sz;
					end
				end
			end
			dd = sz - NW'(1) - m;
			if (m < NW'(3)) begin
				fetch_pt[i] = job.head[m[1:0]];
			end else begin
				fetch_pt[i] = job.win[dd[1:0]];
			end
		end
	end

	function automatic vec_t vsub(input pt_t a, input pt_t b);
		vec_t r;
		r.x = D'(a.x) - D'(b.x);
		r.y = D'(a.y) - D'(b.y);
		return r;
	endfunction

	// zero vectors count as +x
	function automatic vec_t nz(input vec_t a);
		vec_t r;
		r = a;
		if (a.x == '0 && a.y == '0) begin
			r.x = D'(1);
		end
		return r;
	endfunction

	function automatic logic angle_ok(input logic signed [P-1:0] xx,
			input logic signed [P-1:0] yy, input logic signed [P-1:0] xy,
			input logic signed [P-1:0] yx);
		logic signed [S-1:0] dot;
		logic signed [S-1:0] cr;
		logic [S-1:0]        acr;
		logic [CW-1:0]       lhs;
		logic [CW-1:0]       rhs;
		dot = S'(xx) + S'(yy);
		cr  = S'(xy) - S'(yx);
		acr = cr[S-1] ? $unsigned(-cr) : $unsigned(cr);
		lhs = {acr, {TAN_SHIFT{1'b0}}};
		rhs = CW'($unsigned(dot)) * CW'(TAN_NUM);
		return !dot[S-1] && (dot != '0) && (lhs <= rhs);
	endfunction

	function automatic logic near_ok(input logic signed [P-1:0] xx,
			input logic signed [P-1:0] yy, input logic [2*TOL_BITS-1:0] t2);
		logic [S-1:0] d2;
		d2 = S'($unsigned(xx)) + S'($unsigned(yy));
		return QW'(d2) <= QW'(t2);
	endfunction

	logic ang1, ang2, nr3, nr2, nr1;
	logic [2:0] skip;
	logic [NW-1:0] np_nx;
	logic          final_dec;
	logic          decide_go;
	logic          out_free;
	logic          out_load;

	assign ang1 = angle_ok(a1_xx_s3, a1_yy_s3, a1_xy_s3, a1_yx_s3);
	assign ang2 = angle_ok(a2_xx_s3, a2_yy_s3, a2_xy_s3, a2_yx_s3);
	assign nr3  = near_ok(e3_xx_s3, e3_yy_s3, tol2_s3);
	assign nr2  = near_ok(e2_xx_s3, e2_yy_s3, tol2_s3);
	assign nr1  = near_ok(e1_xx_s3, e1_yy_s3, tol2_s3);

	always_comb begin
		if (ang1 && ang2 && nr3) begin
			skip = 3'd4;
		end else if (ang1 && nr2) begin
			skip = 3'd3;
		end else if (nr1) begin
			skip = 3'd2;
		end else begin
			skip = 3'd1;
		end
	end

	assign np_nx     = np_q + NW'(skip);
	assign final_dec = job.last && ((n_q == 2'd3) || (np_nx >= NW'(job.seen)));
	assign decide_go = job.last ? (np_q < NW'(job.seen))
	                            : ((np_q + NW'(4)) <= NW'(job.seen));
	assign out_free  = !out_valid_q || pop;
	assign out_load  = (state_q == ST_DEC) && out_free;

	always_comb begin
		job_pop = 1'b0;
		case (state_q)
			ST_IDLE: job_pop = job_valid && !decide_go;
			ST_DEC:  job_pop = out_free && (!job.last || final_dec);
			default: job_pop = 1'b0;
		endcase
	end

	// ---- datapath stages ----
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			p_s1 <= fetch_pt;
		end
		if (state_q == ST_DIFF) begin
			u1_s2 <= nz(vsub(p_s1[0], p_s1[1]));
			v1_s2 <= nz(vsub(p_s1[2], p_s1[1]));
			u2_s2 <= nz(vsub(p_s1[1], p_s1[2]));
			v2_s2 <= nz(vsub(p_s1[3], p_s1[2]));
			e3_s2 <= vsub(p_s1[0], p_s1[3]);
			e2_s2 <= vsub(p_s1[0], p_s1[2]);
			e1_s2 <= vsub(p_s1[0], p_s1[1]);
		end
		if (state_q == ST_MUL) begin
			a1_xx_s3 <= u1_s2.x * v1_s2.x;
			a1_yy_s3 <= u1_s2.y * v1_s2.y;
			a1_xy_s3 <= u1_s2.x * v1_s2.y;
			a1_yx_s3 <= u1_s2.y * v1_s2.x;
			a2_xx_s3 <= u2_s2.x * v2_s2.x;
			a2_yy_s3 <= u2_s2.y * v2_s2.y;
			a2_xy_s3 <= u2_s2.x * v2_s2.y;
			a2_yx_s3 <= u2_s2.y * v2_s2.x;
			e3_xx_s3 <= e3_s2.x * e3_s2.x;
			e3_yy_s3 <= e3_s2.y * e3_s2.y;
			e2_xx_s3 <= e2_s2.x * e2_s2.x;
			e2_yy_s3 <= e2_s2.y * e2_s2.y;
			e1_xx_s3 <= e1_s2.x * e1_s2.x;
			e1_yy_s3 <= e1_s2.y * e1_s2.y;
			tol2_s3  <= (2*TOL_BITS)'(tolerance) * (2*TOL_BITS)'(tolerance);
		end
		if (state_q == ST_DEC && out_free) begin
			out_x_q   <= p_s1[0].x;
			out_y_q   <= p_s1[0].y;
			out_end_q <= final_dec;
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			np_q        <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !pop);
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (decide_go) begin
							state_q <= ST_FETCH;
						end else if (job.last) begin
							np_q <= '0;
							n_q  <= '0;
						end
					end
				end
				ST_FETCH: state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_DEC;
				ST_DEC: begin
					if (out_free) begin
						if (!job.last) begin
							np_q    <= np_nx;
							state_q <= ST_IDLE;
						end else if (final_dec) begin
							np_q    <= '0;
							n_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							np_q    <= np_nx;
							n_q     <= n_q + 2'd1;
							state_q <= ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty   = !out_valid_q;
	assign out_x   = out_x_q;
	assign out_y   = out_y_q;
	assign out_end = out_end_q;

	// ---- checks ----
	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job taken from an empty queue");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> job_valid)
		else $error("job lost while a decision is in flight");

	a_mid_ring_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && !job.last) |-> (n_q == 2'd0))
		else $error("decision count running outside a ring end");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && out_valid_q && !pop) |=> out_valid_q)
		else $error("waiting result dropped");

endmodule

`default_nettype wire

FILE: hw/rtl/ring_spike_zigzag_cleaner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_spike_zigzag_cleaner
// Removes spikes, zigzags and repeated points from a streamed closed ring.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  input     push, full, x_coord, y_coord,    push && !full
//            ring_end
//  result    empty, pop, out_x, out_y,        pop && !empty
//            out_end
//  config    cfg_we, cfg_wdata (tolerance)    cfg_we
//
//  a vertex enters the two-entry job queue; the back takes a job and walks
//  each kept vertex through fetch, difference, multiply and decide, one job
//  at a time and up to four kept vertices at a ring end. the decision unit
//  is shared and sets the rate. the queue lets input continue while a result
//  waits, until its two entries fill. reset clears counters and control.
// ----------------------------------------------------------------------------
module ring_spike_zigzag_cleaner #(
	parameter int COORD_BITS      = rszc_pkg::COORD_BITS_DEF,
	parameter int MAX_RING_POINTS = rszc_pkg::MAX_RING_POINTS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic signed [COORD_BITS-1:0]           x_coord,
	input  wire logic signed [COORD_BITS-1:0]           y_coord,
	input  wire logic                                   ring_end,
	output logic                                        empty,
	input  wire logic                                   pop,
	output logic signed [COORD_BITS-1:0]                out_x,
	output logic signed [COORD_BITS-1:0]                out_y,
	output logic                                        out_end,
	input  wire logic                                   cfg_we,
	input  wire logic [rszc_pkg::TOL_BITS-1:0]          cfg_wdata
);
	import rszc_pkg::*;

	localparam int JW = 14 * COORD_BITS + seen_bits(MAX_RING_POINTS) + 1;

	logic [TOL_BITS-1:0] tolerance_q;
	logic [JW-1:0]       job_wdata;
	logic [JW-1:0]       job_rdata;
	logic                job_push;
	logic                job_full;
	logic                job_empty;
	logic                job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (cfg_we) begin
			tolerance_q <= cfg_wdata;
		end
	end

	rszc_front #(
		.COORD_BITS      (COORD_BITS),
		.MAX_RING_POINTS (MAX_RING_POINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.ring_end (ring_end),
		.job_data (job_wdata),
		.job_push (job_push),
		.job_full (job_full)
	);

	rszc_queue #(
		.WIDTH (JW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_data  (job_wdata),
		.is_full  (job_full),
		.rd_en    (job_pop),
		.rd_data  (job_rdata),
		.is_empty (job_empty)
	);

	rszc_back #(
		.COORD_BITS      (COORD_BITS),
		.MAX_RING_POINTS (MAX_RING_POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_data  (job_rdata),
		.job_valid (!job_empty),
		.job_pop   (job_pop),
		.tolerance (tolerance_q),
		.empty     (empty),
		.pop       (pop),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_end   (out_end)
	);

endmodule

`default_nettype wire

FILE: verif/ring_spike_zigzag_cleaner_tb.sv
// ----------------------------------------------------------------------------
// ring_spike_zigzag_cleaner_tb
// Streams closed rings through the cleaner, predicts every kept vertex with
// an independent model of the skip rules and checks the result queue field
// by field, under random idling on both sides and several tolerances.
// ----------------------------------------------------------------------------
module ring_spike_zigzag_cleaner_tb;
	import rszc_pkg::*;

	localparam int CB        = COORD_BITS_DEF;
	localparam int RING_MAX  = MAX_RING_POINTS_DEF;
	localparam int CYC_LIMIT = 400000;
	localparam int SETTLE    = 40;

	typedef logic signed [CB-1:0] coord_t;
	typedef struct {
		coord_t x;
		coord_t y;
		logic   fin;
	} vertex_t;
	typedef struct {
		longint x;
		longint y;
	} pt_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	coord_t x_coord;
	coord_t y_coord;
	logic ring_end;
	logic empty;
	logic pop;
	coord_t out_x;
	coord_t out_y;
	logic out_end;
	logic cfg_we;
	logic [TOL_BITS-1:0] cfg_wdata;

	ring_spike_zigzag_cleaner DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .x_coord(x_coord), .y_coord(y_coord),
		.ring_end(ring_end),
		.empty(empty), .pop(pop), .out_x(out_x), .out_y(out_y), .out_end(out_end),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	vertex_t pending_vertices[$];
	vertex_t kept_vertices[$];
	int mismatches = 0;
	int cycles = 0;
	bit idling = 1;

	// cleaner state as predicted
	pt_t win_pts[4];
	pt_t head_pts[3];
	int unsigned seen_cnt;
	int unsigned next_pos;
	longint tol_val;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic bit narrow_angle(pt_t a, pt_t b, pt_t c);
		longint ux, uy, vx, vy, dot, cr;
		logic [79:0] lhs, rhs;
		ux = a.x - b.x; uy = a.y - b.y;
		vx = c.x - b.x; vy = c.y - b.y;
		// a zero-length leg points along +x
		if (ux == 0 && uy == 0) ux = 1;
		if (vx == 0 && vy == 0) vx = 1;
		dot = ux * vx + uy * vy;
		if (dot <= 0) return 0;
		cr = ux * vy - uy * vx;
		if (cr < 0) cr = -cr;
		lhs = 80'(cr) << TAN_SHIFT;
		rhs = 80'(dot) * 80'(TAN_NUM);
		return lhs <= rhs;
	endfunction

	function automatic bit within_tol(pt_t a, pt_t b);
		longint dx, dy;
		dx = a.x - b.x; dy = a.y - b.y;
		return (dx * dx + dy * dy) <= tol_val * tol_val;
	endfunction

	function automatic pt_t ring_point(int unsigned m);
		pt_t z;
		int unsigned d;
		z.x = 0; z.y = 0;
		if (m < 3) return head_pts[m];
		if (m >= seen_cnt) return z;
		d = seen_cnt - 1 - m;
		if (d < 4) return win_pts[d];
		return z;
	endfunction

	task automatic keep_and_skip(bit wrap);
		pt_t p[4];
		vertex_t v;
		int unsigned m;
		for (int i = 0; i < 4; i++) begin
			m = next_pos + i;
			if (wrap && seen_cnt != 0) m = m % seen_cnt;
			p[i] = ring_point(m);
		end
		v.x = coord_t'(p[0].x);
		v.y = coord_t'(p[0].y);
		v.fin = 0;
		kept_vertices.push_back(v);
		if (narrow_angle(p[0], p[1], p[2]) && narrow_angle(p[1], p[2], p[3])
				&& within_tol(p[0], p[3]))
			next_pos += 4;
		else if (narrow_angle(p[0], p[1], p[2]) && within_tol(p[0], p[2]))
			next_pos += 3;
		else if (within_tol(p[0], p[1]))
			next_pos += 2;
		else
			next_pos += 1;
	endtask

	task automatic predict_vertex(coord_t xv, coord_t yv, logic e);
		pt_t v;
		int n;
		bit last;
		n = 0;
		v.x = longint'(xv);
		v.y = longint'(yv);
		for (int i = 3; i > 0; i--) win_pts[i] = win_pts[i-1];
		win_pts[0] = v;
		if (seen_cnt < 3) head_pts[seen_cnt] = v;
		seen_cnt++;
		last = e || seen_cnt >= RING_MAX;
		if (!last) begin
			while (n < 4 && next_pos + 4 <= seen_cnt) begin
				keep_and_skip(0);
				n++;
			end
		end else begin
			while (n < 4 && next_pos < seen_cnt) begin
				keep_and_skip(1);
				n++;
			end
			if (n > 0) kept_vertices[$].fin = 1;
			seen_cnt = 0;
			next_pos = 0;
		end
	endtask

	function automatic int draw_gap();
		int r;
		if (!idling) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// input side: accept on the rising edge, drive on the falling edge
	logic in_took;
	int in_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 0;
		end else begin
			in_took <= push && !full;
			if (push && !full) begin
				predict_vertex(x_coord, y_coord, ring_end);
				void'(pending_vertices.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_took) in_gap = draw_gap();
			if (in_gap > 0) begin
				in_gap--;
				push <= 0;
			end else if (pending_vertices.size() > 0) begin
				push <= 1;
				x_coord <= pending_vertices[0].x;
				y_coord <= pending_vertices[0].y;
				ring_end <= pending_vertices[0].fin;
			end else begin
				push <= 0;
			end
		end
	end

	// result side
	logic out_took;
	int out_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_took <= 0;
		end else begin
			cycles <= cycles + 1;
			out_took <= pop && !empty;
			if (pop && !empty) begin
				if (kept_vertices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: x=%0d y=%0d end=%0b",
							out_x, out_y, out_end);
				end else begin
					if (out_x !== kept_vertices[0].x || out_y !== kept_vertices[0].y
							|| out_end !== kept_vertices[0].fin) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
								kept_vertices[0].x, kept_vertices[0].y, kept_vertices[0].fin,
								out_x, out_y, out_end);
					end
					void'(kept_vertices.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) out_gap = draw_gap();
			if (out_gap > 0) begin
				out_gap--;
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYC_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_vertex(longint xv, longint yv, bit e);
		vertex_t v;
		v.x = coord_t'(xv);
		v.y = coord_t'(yv);
		v.fin = e;
		pending_vertices.push_back(v);
	endtask

	task automatic wait_idle();
		while (pending_vertices.size() > 0 || kept_vertices.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [TOL_BITS-1:0] t);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_we <= 0;
		tol_val = longint'(t);
	endtask

	// rings mostly of clustered or collinear points so spikes and zigzags occur
	task automatic random_ring(int len);
		longint bx, by, dx, dy, k;
		int r;
		bx = $signed($urandom_range(0, 16000000)) - 8000000;
		by = $signed($urandom_range(0, 16000000)) - 8000000;
		dx = $signed($urandom_range(0, 6)) - 3;
		dy = $signed($urandom_range(0, 6)) - 3;
		if ($urandom_range(0, 3) == 0) begin
			dx = dx * 1000;
			dy = dy * 1000;
		end
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				add_vertex(longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
					i == len - 1);
			end else if (r < 4) begin
				add_vertex(bx + $signed($urandom_range(0, 6)) - 3,
					by + $signed($urandom_range(0, 6)) - 3, i == len - 1);
			end else begin
				k = $signed($urandom_range(0, 40)) - 20;
				add_vertex(bx + k * dx + $signed($urandom_range(0, 2)) - 1,
					by + k * dy, i == len - 1);
			end
		end
	endtask

	task automatic random_phase(int n_items);
		int sent, len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			random_ring(len);
			sent += len;
		end
	endtask

	initial begin
		logic [TOL_BITS-1:0] tols[5];
		arst_n = 0;
		push = 0;
		pop = 0;
		x_coord = '0;
		y_coord = '0;
		ring_end = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		foreach (win_pts[i]) begin
			win_pts[i].x = 0;
			win_pts[i].y = 0;
		end
		foreach (head_pts[i]) begin
			head_pts[i].x = 0;
			head_pts[i].y = 0;
		end
		seen_cnt = 0;
		next_pos = 0;
		tol_val = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (2) @(posedge clk);

		// directed rings at a moderate tolerance
		set_tolerance(50);
		add_vertex(8388607, 8388607, 1);
		add_vertex(-8388608, -8388608, 0);
		add_vertex(8388607, 8388607, 1);
		add_vertex(0, 0, 0);
		add_vertex(0, 0, 0);
		add_vertex(5, 0, 1);
		// spike
		add_vertex(0, 0, 0);
		add_vertex(100, 0, 0);
		add_vertex(1, 0, 0);
		add_vertex(50, 50, 0);
		add_vertex(0, 60, 1);
		// zigzag
		add_vertex(0, 0, 0);
		add_vertex(100, 0, 0);
		add_vertex(1, 0, 0);
		add_vertex(40, 0, 0);
		add_vertex(0, 80, 0);
		add_vertex(-30, 40, 1);
		// repeats across the wrap
		add_vertex(7, 7, 0);
		add_vertex(-8388608, 8388607, 0);
		add_vertex(7, 8, 1);
		wait_idle();

		tols[0] = 0;
		tols[1] = 24'hFFFFFF;
		tols[2] = 3;
		tols[3] = 200;
		tols[4] = TOL_BITS'($urandom);
		for (int ph = 0; ph < 5; ph++) begin
			set_tolerance(tols[ph]);
			idling = (ph != 2);
			random_phase(96);
			wait_idle();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && kept_vertices.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: ring_spike_zigzag_cleaner.f
hw/rtl/rszc_pkg.sv
hw/rtl/rszc_front.sv
hw/rtl/rszc_queue.sv
hw/rtl/rszc_back.sv
hw/rtl/ring_spike_zigzag_cleaner.sv
verif/ring_spike_zigzag_cleaner_tb.sv
